>>> rtl/modbus_rtu_frame_receiver_unit_defines.svh
// ----------------------------------------------------------------------------
// Modbus RTU frame receiver assertion macros
// Shared property forms for the port checker; clk and arst_n come from scope.
// ----------------------------------------------------------------------------
`ifndef MODBUS_RTU_FRAME_RECEIVER_UNIT_DEFINES_SVH
`define MODBUS_RTU_FRAME_RECEIVER_UNIT_DEFINES_SVH

// same-cycle implication
`define MBRTU_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("mbrtu same-cycle check failed");

// next-cycle implication
`define MBRTU_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("mbrtu next-cycle check failed");

`endif

>>> rtl/mbrtu_pkg.sv
// ----------------------------------------------------------------------------
// mbrtu_pkg
// Opcodes, status codes, result and counter types, CRC-16 and saturation helpers.
// ----------------------------------------------------------------------------
package mbrtu_pkg;

	localparam logic [1:0] OP_BYTE = 2'd0;
	localparam logic [1:0] OP_TICK = 2'd1;
	localparam logic [1:0] OP_READ = 2'd2;

	localparam logic [2:0] ST_OWN       = 3'd0;
	localparam logic [2:0] ST_BROADCAST = 3'd1;
	localparam logic [2:0] ST_FOREIGN   = 3'd2;
	localparam logic [2:0] ST_EMPTY     = 3'd3;
	localparam logic [2:0] ST_SHORT     = 3'd4;
	localparam logic [2:0] ST_CRC_ERR   = 3'd5;
	localparam logic [2:0] ST_READ      = 3'd6;

	localparam logic [15:0] CRC_INIT   = 16'hFFFF;
	localparam logic [15:0] CRC_POLY   = 16'hA001;
	localparam logic [15:0] SAT16      = 16'hFFFF;
	localparam logic [7:0]  BCAST_ADDR = 8'h00;
	localparam logic [7:0]  CRC_TAIL   = 8'd3;

	typedef struct packed {
		logic       valid;
		logic [2:0] status;
		logic [7:0] addr;
		logic [7:0] pdu;
	} frame_res_t;

	typedef struct packed {
		logic [31:0] frames;
		logic [31:0] own;
		logic [15:0] short_cnt;
		logic [15:0] crc_err;
		logic [15:0] ovf;
	} counts_t;

	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

	function automatic logic [15:0] sat_inc16(input logic [15:0] v);
		return (v != SAT16) ? v + 16'd1 : v;
	endfunction

endpackage

>>> rtl/mbrtu_store.sv
// ----------------------------------------------------------------------------
// mbrtu_store
// Frame byte buffer: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module mbrtu_store #(
	parameter int DEPTH = 256,
	parameter int AW    = 8
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [7:0]    wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [7:0]    rd_data
);

	logic [7:0] mem [DEPTH];
	logic [7:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

>>> rtl/mbrtu_core.sv
// ----------------------------------------------------------------------------
// mbrtu_core
// Fill, CRC and gap tracking, frame-end classification and event counters.
// ----------------------------------------------------------------------------
module mbrtu_core #(
	parameter int BUFFER_BYTES    = 256,
	parameter int MIN_FRAME_BYTES = 4,
	parameter int AW              = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic [1:0]           opcode,
	input  logic [7:0]           data_byte,
	input  logic [7:0]           own_address,
	input  logic [15:0]          gap_ticks,
	output logic                 wr_en,
	output logic [AW-1:0]        wr_addr,
	output mbrtu_pkg::frame_res_t res,
	output mbrtu_pkg::counts_t   counts
);

	logic [AW-1:0] fill_q;
	logic [15:0]   crc_q;
	logic [15:0]   gap_q;
	logic          run_q;
	logic [7:0]    first_q;
	mbrtu_pkg::counts_t cnt_q;

	logic        is_byte;
	logic        is_tick;
	logic        ovf;
	logic [15:0] crc_nx;
	logic [15:0] gap_inc;
	logic        frame_end;
	logic        too_short;
	logic [7:0]  pdu_len;

	assign is_byte   = en && (opcode == mbrtu_pkg::OP_BYTE);
	assign is_tick   = en && (opcode == mbrtu_pkg::OP_TICK) && run_q;
	assign ovf       = (fill_q == AW'(BUFFER_BYTES - 1));
	assign wr_en     = is_byte;
	assign wr_addr   = ovf ? '0 : fill_q;
	assign crc_nx    = mbrtu_pkg::crc_byte(ovf ? mbrtu_pkg::CRC_INIT : crc_q, data_byte);
	assign gap_inc   = mbrtu_pkg::sat_inc16(gap_q);
	assign frame_end = is_tick && (gap_inc >= gap_ticks);
	assign too_short = ({1'b0, fill_q} < (AW + 1)'(MIN_FRAME_BYTES));
	assign pdu_len   = 8'(fill_q) - mbrtu_pkg::CRC_TAIL;

	always_comb begin
		res.valid  = frame_end;
		res.status = mbrtu_pkg::ST_EMPTY;
		res.addr   = 8'd0;
		res.pdu    = 8'd0;
		if (fill_q != '0) begin
			res.addr = first_q;
			if (too_short) begin
				res.status = mbrtu_pkg::ST_SHORT;
			end else if (crc_q != 16'd0) begin
				res.status = mbrtu_pkg::ST_CRC_ERR;
			end else begin
				res.pdu = pdu_len;
				if (first_q == mbrtu_pkg::BCAST_ADDR) begin
					res.status = mbrtu_pkg::ST_BROADCAST;
				end else if (first_q == own_address) begin
					res.status = mbrtu_pkg::ST_OWN;
				end else begin
					res.status = mbrtu_pkg::ST_FOREIGN;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			crc_q  <= mbrtu_pkg::CRC_INIT;
			gap_q  <= 16'd0;
			run_q  <= 1'b0;
			cnt_q  <= '0;
		end else if (is_byte) begin
			fill_q <= wr_addr + AW'(1);
			crc_q  <= crc_nx;
			gap_q  <= 16'd0;
			run_q  <= 1'b1;
			if (ovf) begin
				cnt_q.ovf <= mbrtu_pkg::sat_inc16(cnt_q.ovf);
			end
		end else if (frame_end) begin
			fill_q       <= '0;
			crc_q        <= mbrtu_pkg::CRC_INIT;
			gap_q        <= 16'd0;
			run_q        <= 1'b0;
			cnt_q.frames <= cnt_q.frames + 32'd1;
			if (res.status == mbrtu_pkg::ST_SHORT) begin
				cnt_q.short_cnt <= mbrtu_pkg::sat_inc16(cnt_q.short_cnt);
			end
			if (res.status == mbrtu_pkg::ST_CRC_ERR) begin
				cnt_q.crc_err <= mbrtu_pkg::sat_inc16(cnt_q.crc_err);
			end
			if (res.status == mbrtu_pkg::ST_OWN) begin
				cnt_q.own <= cnt_q.own + 32'd1;
			end
		end else if (is_tick) begin
			gap_q <= gap_inc;
		end
	end

	always_ff @(posedge clk) begin
		if (is_byte && (wr_addr == '0)) begin
			first_q <= data_byte;
		end
	end

	assign counts = cnt_q;

endmodule

>>> rtl/modbus_rtu_frame_receiver_unit.sv
// ----------------------------------------------------------------------------
// modbus_rtu_frame_receiver_unit
// A result passes the input register, then the result register and the buffer
// read register. Throughput: one beat per cycle, held back only while a result
// waits on out_ready.
// Reset clears fill, gap timer, counters and valid flags and presets CRC and config; buffer is not cleared.
// ----------------------------------------------------------------------------
module modbus_rtu_frame_receiver_unit #(
	parameter int BUFFER_BYTES    = 256,
	parameter int MIN_FRAME_BYTES = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  opcode,
	input  logic [7:0]  data_byte,
	input  logic [7:0]  read_index,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic [7:0]  frame_address,
	output logic [7:0]  pdu_length,
	output logic [7:0]  read_byte,
	output logic [31:0] frames_seen,
	output logic [31:0] own_frame_count,
	output logic [15:0] short_count,
	output logic [15:0] crc_error_count,
	output logic [15:0] overflow_count,
	input  logic        cfg_write_en,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data
);

	localparam int  AW       = $clog2(BUFFER_BYTES);
	localparam logic REG_OWN = 1'b0;
	localparam logic REG_GAP = 1'b1;

	logic        valid_s1;
	logic [1:0]  opcode_s1;
	logic [7:0]  byte_s1;
	logic [7:0]  index_s1;
	logic [7:0]  own_addr_q;
	logic [15:0] gap_ticks_q;
	logic        out_valid_q;
	logic [2:0]  status_q;
	logic [7:0]  addr_q;
	logic [7:0]  pdu_q;
	logic        rd_ok_q;

	logic        adv;
	logic        is_read;
	logic        in_range;
	logic        wr_en;
	logic [AW-1:0] wr_addr;
	logic [7:0]  rd_data;
	mbrtu_pkg::frame_res_t res;
	mbrtu_pkg::counts_t    counts;

	assign adv      = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv;
	assign is_read  = (opcode_s1 == mbrtu_pkg::OP_READ);
	assign in_range = ({1'b0, index_s1} < 9'(BUFFER_BYTES));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_addr_q  <= 8'd1;
			gap_ticks_q <= 16'd5;
		end else if (cfg_write_en) begin
			case (cfg_index)
				REG_OWN: own_addr_q  <= cfg_data[7:0];
				REG_GAP: gap_ticks_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			opcode_s1 <= opcode;
			byte_s1   <= data_byte;
			index_s1  <= read_index;
		end
	end

	mbrtu_core #(
		.BUFFER_BYTES   (BUFFER_BYTES),
		.MIN_FRAME_BYTES(MIN_FRAME_BYTES),
		.AW             (AW)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (adv),
		.opcode     (opcode_s1),
		.data_byte  (byte_s1),
		.own_address(own_addr_q),
		.gap_ticks  (gap_ticks_q),
		.wr_en      (wr_en),
		.wr_addr    (wr_addr),
		.res        (res),
		.counts     (counts)
	);

	mbrtu_store #(
		.DEPTH(BUFFER_BYTES),
		.AW   (AW)
	) u_store (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(byte_s1),
		.rd_en  (adv && is_read),
		.rd_addr(index_s1[AW-1:0]),
		.rd_data(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= res.valid || is_read;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (is_read) begin
				status_q <= mbrtu_pkg::ST_READ;
				addr_q   <= 8'd0;
				pdu_q    <= 8'd0;
				rd_ok_q  <= in_range;
			end else begin
				status_q <= res.status;
				addr_q   <= res.addr;
				pdu_q    <= res.pdu;
				rd_ok_q  <= 1'b0;
			end
		end
	end

	assign out_valid       = out_valid_q;
	assign status          = status_q;
	assign frame_address   = addr_q;
	assign pdu_length      = pdu_q;
	assign read_byte       = rd_ok_q ? rd_data : 8'd0;
	assign frames_seen     = counts.frames;
	assign own_frame_count = counts.own;
	assign short_count     = counts.short_cnt;
	assign crc_error_count = counts.crc_err;
	assign overflow_count  = counts.ovf;

endmodule

>>> rtl/mbrtu_checker.sv
// ----------------------------------------------------------------------------
// mbrtu_checker
// Port-level checks on result beats of the frame receiver.
// ----------------------------------------------------------------------------
`include "modbus_rtu_frame_receiver_unit_defines.svh"

module mbrtu_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [2:0]  status,
	input logic [7:0]  frame_address,
	input logic [7:0]  pdu_length,
	input logic [31:0] frames_seen
);

	`MBRTU_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid)
	`MBRTU_ASSERT_NXT(a_count_frozen, out_valid && !out_ready, $stable(frames_seen))
	`MBRTU_ASSERT_IMP(a_read_clean, out_valid && (status == mbrtu_pkg::ST_READ), (frame_address == 8'd0) && (pdu_length == 8'd0))
	`MBRTU_ASSERT_IMP(a_bad_no_pdu, out_valid && ((status == mbrtu_pkg::ST_EMPTY) || (status == mbrtu_pkg::ST_SHORT) || (status == mbrtu_pkg::ST_CRC_ERR)), pdu_length == 8'd0)

endmodule

bind modbus_rtu_frame_receiver_unit mbrtu_checker u_mbrtu_checker (.*);
